[hw/rtl/lpw_pkg.sv]
// ----------------------------------------------------------------------------
// lpw_pkg
// shared request codes and octant codes for the line pixel walker
// ----------------------------------------------------------------------------
package lpw_pkg;

    typedef enum logic [0:0] {
        REQ_LOAD    = 1'b0,
        REQ_ADVANCE = 1'b1
    } t_req_type;

    typedef enum logic [2:0] {
        OCT_0 = 3'd0,
        OCT_1 = 3'd1,
        OCT_2 = 3'd2,
        OCT_3 = 3'd3,
        OCT_4 = 3'd4,
        OCT_5 = 3'd5,
        OCT_6 = 3'd6,
        OCT_7 = 3'd7
    } t_octant;

endpackage

[hw/rtl/lpw_req_if.sv]
// ----------------------------------------------------------------------------
// lpw_req_if
// request channel: load endpoints or advance one pixel
// ----------------------------------------------------------------------------
interface lpw_req_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, req_type, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, req_type, start_x, start_y, end_x, end_y, output ready);
endinterface

[hw/rtl/lpw_pix_if.sv]
// ----------------------------------------------------------------------------
// lpw_pix_if
// pixel channel: one walked pixel per request
// ----------------------------------------------------------------------------
interface lpw_pix_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         pixel_valid;
    logic                         last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_valid, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_valid, last_pixel, output ready);
endinterface

[hw/rtl/line_pixel_walker.sv]
// ----------------------------------------------------------------------------
// line_pixel_walker
// bresenham line walker with octant folding, one pixel per request
// ----------------------------------------------------------------------------
// path: a request passes the input register, then the result register, before
//   its pixel shows on o_pix; a stall on o_pix holds the result register
// throughput: 1 request per cycle while o_pix is ready; the walk state loop
//   (error add, step) adds no register, so back-to-back advances run at full rate
// reset: synchronous active-low i_rst_n empties both stages and drops the line
// ----------------------------------------------------------------------------
module line_pixel_walker #(
    parameter int COORD_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpw_req_if.sink    i_req,
    lpw_pix_if.source  o_pix
);
    import lpw_pkg::*;

    localparam int W = COORD_BITS;

    // input register stage
    logic              r_s1_valid;
    t_req_type         r_s1_type;
    logic signed [W-1:0] r_s1_sx, r_s1_sy, r_s1_ex, r_s1_ey;

    // line walk state, all in octant-zero space
    t_octant             r_octant,  n_octant;
    logic signed [W:0]   r_walk_x,  n_walk_x;
    logic signed [W:0]   r_walk_y,  n_walk_y;
    logic signed [W:0]   r_final_x, n_final_x;
    logic signed [W+3:0] r_error,   n_error;
    logic        [W+2:0] r_snr,     n_snr;
    logic signed [W+2:0] r_swr,     n_swr;
    logic                r_line_active, n_line_active;

    // result register stage
    logic                r_out_valid;
    logic signed [W-1:0] r_pix_x, n_pix_x;
    logic signed [W-1:0] r_pix_y, n_pix_y;
    logic                r_pix_valid, n_pix_valid;
    logic                r_last, n_last;

    // handshake: result register moves when empty or drained
    logic w_adv;
    logic w_fire;

    // load path
    t_octant             w_ld_oct;
    logic signed [W:0]   w_ld_wx, w_ld_wy, w_ld_fx;
    logic signed [W+3:0] w_ld_err;
    logic        [W+2:0] w_ld_snr;
    logic signed [W+2:0] w_ld_swr;
    logic                w_ld_single;

    // advance path
    logic signed [W:0]   w_st_wx, w_st_wy;
    logic signed [W+3:0] w_st_err;
    logic                w_st_last;
    logic signed [W-1:0] w_st_px, w_st_py;

    assign w_adv       = !r_out_valid || o_pix.ready;
    assign w_fire      = r_s1_valid && w_adv;
    assign i_req.ready = !r_s1_valid || w_adv;

    lpw_line_setup #(.COORD_BITS(W)) u_setup (
        .i_start_x        (r_s1_sx),
        .i_start_y        (r_s1_sy),
        .i_end_x          (r_s1_ex),
        .i_end_y          (r_s1_ey),
        .o_octant         (w_ld_oct),
        .o_walk_x         (w_ld_wx),
        .o_walk_y         (w_ld_wy),
        .o_final_x        (w_ld_fx),
        .o_error          (w_ld_err),
        .o_step_no_rise   (w_ld_snr),
        .o_step_with_rise (w_ld_swr),
        .o_single         (w_ld_single)
    );

    lpw_walk_step #(.COORD_BITS(W)) u_step (
        .i_walk_x         (r_walk_x),
        .i_walk_y         (r_walk_y),
        .i_final_x        (r_final_x),
        .i_error          (r_error),
        .i_step_no_rise   (r_snr),
        .i_step_with_rise (r_swr),
        .o_walk_x         (w_st_wx),
        .o_walk_y         (w_st_wy),
        .o_error          (w_st_err),
        .o_last           (w_st_last)
    );

    lpw_octant_unfold #(.COORD_BITS(W)) u_unfold (
        .i_octant  (r_octant),
        .i_walk_x  (w_st_wx),
        .i_walk_y  (w_st_wy),
        .o_pixel_x (w_st_px),
        .o_pixel_y (w_st_py)
    );

    always_comb begin
        n_octant      = r_octant;
        n_walk_x      = r_walk_x;
        n_walk_y      = r_walk_y;
        n_final_x     = r_final_x;
        n_error       = r_error;
        n_snr         = r_snr;
        n_swr         = r_swr;
        n_line_active = r_line_active;
        n_pix_x       = r_pix_x;
        n_pix_y       = r_pix_y;
        n_pix_valid   = r_pix_valid;
        n_last        = r_last;
        if (w_fire) begin
            case (r_s1_type)
                REQ_LOAD: begin
                    // a load always abandons any line in progress
                    n_octant      = w_ld_oct;
                    n_walk_x      = w_ld_wx;
                    n_walk_y      = w_ld_wy;
                    n_final_x     = w_ld_fx;
                    n_error       = w_ld_err;
                    n_snr         = w_ld_snr;
                    n_swr         = w_ld_swr;
                    n_line_active = !w_ld_single;
                    // unfold of the folded start is the start itself
                    n_pix_x       = r_s1_sx;
                    n_pix_y       = r_s1_sy;
                    n_pix_valid   = 1'b1;
                    n_last        = w_ld_single;
                end
                REQ_ADVANCE: begin
                    if (r_line_active) begin
                        n_walk_x      = w_st_wx;
                        n_walk_y      = w_st_wy;
                        n_error       = w_st_err;
                        n_line_active = !w_st_last;
                        n_pix_x       = w_st_px;
                        n_pix_y       = w_st_py;
                        n_pix_valid   = 1'b1;
                        n_last        = w_st_last;
                    end else begin
                        // no line: empty result, state untouched
                        n_pix_x     = '0;
                        n_pix_y     = '0;
                        n_pix_valid = 1'b0;
                        n_last      = 1'b0;
                    end
                end
                default: begin
                    n_pix_valid = 1'b0;
                    n_last      = 1'b0;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_line_active <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_s1_valid;
            end
            r_line_active <= n_line_active;
        end
    end

    // payload and walk datapath
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_s1_type <= t_req_type'(i_req.req_type);
            r_s1_sx   <= i_req.start_x;
            r_s1_sy   <= i_req.start_y;
            r_s1_ex   <= i_req.end_x;
            r_s1_ey   <= i_req.end_y;
        end
        r_octant    <= n_octant;
        r_walk_x    <= n_walk_x;
        r_walk_y    <= n_walk_y;
        r_final_x   <= n_final_x;
        r_error     <= n_error;
        r_snr       <= n_snr;
        r_swr       <= n_swr;
        r_pix_x     <= n_pix_x;
        r_pix_y     <= n_pix_y;
        r_pix_valid <= n_pix_valid;
        r_last      <= n_last;
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.pixel_x     = r_pix_x;
    assign o_pix.pixel_y     = r_pix_y;
    assign o_pix.pixel_valid = r_pix_valid;
    assign o_pix.last_pixel  = r_last;

    // an active line has not reached its end point yet
    a_walk_before_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> (r_walk_x < r_final_x))
        else $error("active line at or past its end point");

    // delivering the last pixel always ends the line
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && n_last) |=> !r_line_active)
        else $error("line still active after last pixel");

    // an empty result carries zero fields
    a_empty_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && !o_pix.pixel_valid) |->
            (o_pix.pixel_x == '0 && o_pix.pixel_y == '0 && !o_pix.last_pixel))
        else $error("empty result with nonzero fields");

    // a last pixel is always a real pixel
    a_last_is_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.last_pixel) |-> o_pix.pixel_valid)
        else $error("last flag on an empty result");

endmodule

[hw/rtl/lpw_line_setup.sv]
// ----------------------------------------------------------------------------
// lpw_line_setup
// octant pick, fold into octant zero and bresenham preset for a load
// ----------------------------------------------------------------------------
module lpw_line_setup #(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output lpw_pkg::t_octant             o_octant,
    output logic signed [COORD_BITS:0]   o_walk_x,
    output logic signed [COORD_BITS:0]   o_walk_y,
    output logic signed [COORD_BITS:0]   o_final_x,
    output logic signed [COORD_BITS+3:0] o_error,
    output logic        [COORD_BITS+2:0] o_step_no_rise,
    output logic signed [COORD_BITS+2:0] o_step_with_rise,
    output logic                         o_single
);
    import lpw_pkg::*;

    localparam int W = COORD_BITS;

    logic signed [W:0]   w_sx, w_sy, w_ex, w_ey;
    logic signed [W:0]   w_ddx, w_ddy;
    logic signed [W+1:0] w_dxe, w_dye, w_ndx, w_ndy;
    logic signed [W:0]   w_fdx, w_fdy;
    t_octant             w_oct;

    // folded x for a point (a, b)
    function automatic logic signed [W:0] fold_x(t_octant oct, logic signed [W:0] a,
                                                 logic signed [W:0] b);
        logic signed [W:0] r;
        case (oct)
            OCT_0, OCT_7: r = a;
            OCT_1, OCT_2: r = b;
            OCT_3, OCT_4: r = -a;
            OCT_5, OCT_6: r = -b;
            default:      r = a;
        endcase
        return r;
    endfunction

    // folded y for a point (a, b)
    function automatic logic signed [W:0] fold_y(t_octant oct, logic signed [W:0] a,
                                                 logic signed [W:0] b);
        logic signed [W:0] r;
        case (oct)
            OCT_0, OCT_3: r = b;
            OCT_1, OCT_6: r = a;
            OCT_2, OCT_5: r = -a;
            OCT_4, OCT_7: r = -b;
            default:      r = b;
        endcase
        return r;
    endfunction

    assign w_sx  = {i_start_x[W-1], i_start_x};
    assign w_sy  = {i_start_y[W-1], i_start_y};
    assign w_ex  = {i_end_x[W-1], i_end_x};
    assign w_ey  = {i_end_y[W-1], i_end_y};
    assign w_ddx = w_ex - w_sx;
    assign w_ddy = w_ey - w_sy;
    assign w_dxe = {w_ddx[W], w_ddx};
    assign w_dye = {w_ddy[W], w_ddy};
    assign w_ndx = -w_dxe;
    assign w_ndy = -w_dye;

    // direction ties go to the octant nearer the y axis
    always_comb begin
        if (!w_dxe[W+1]) begin
            if (!w_dye[W+1]) begin
                w_oct = (w_dye >= w_dxe) ? OCT_1 : OCT_0;
            end else begin
                w_oct = (w_ndy >= w_dxe) ? OCT_6 : OCT_7;
            end
        end else begin
            if (!w_dye[W+1]) begin
                w_oct = (w_dye >= w_ndx) ? OCT_2 : OCT_3;
            end else begin
                w_oct = (w_dye <= w_dxe) ? OCT_5 : OCT_4;
            end
        end
    end

    // folding is linear, so the delta folds the same way as the points
    assign w_fdx = fold_x(w_oct, w_ddx, w_ddy);
    assign w_fdy = fold_y(w_oct, w_ddx, w_ddy);

    assign o_octant         = w_oct;
    assign o_walk_x         = fold_x(w_oct, w_sx, w_sy);
    assign o_walk_y         = fold_y(w_oct, w_sx, w_sy);
    assign o_final_x        = fold_x(w_oct, w_ex, w_ey);
    assign o_error          = {{2{w_fdy[W]}}, w_fdy, 1'b0} - {{3{w_fdx[W]}}, w_fdx};
    assign o_step_no_rise   = {1'b0, w_fdy, 1'b0};
    assign o_step_with_rise = {w_fdy[W], w_fdy, 1'b0} - {w_fdx[W], w_fdx, 1'b0};
    assign o_single         = (w_fdx == '0);

endmodule

[hw/rtl/lpw_walk_step.sv]
// ----------------------------------------------------------------------------
// lpw_walk_step
// one bresenham step in octant-zero space
// ----------------------------------------------------------------------------
module lpw_walk_step #(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS:0]   i_walk_x,
    input  logic signed [COORD_BITS:0]   i_walk_y,
    input  logic signed [COORD_BITS:0]   i_final_x,
    input  logic signed [COORD_BITS+3:0] i_error,
    input  logic        [COORD_BITS+2:0] i_step_no_rise,
    input  logic signed [COORD_BITS+2:0] i_step_with_rise,
    output logic signed [COORD_BITS:0]   o_walk_x,
    output logic signed [COORD_BITS:0]   o_walk_y,
    output logic signed [COORD_BITS+3:0] o_error,
    output logic                         o_last
);
    localparam int W = COORD_BITS;

    logic w_rise;

    assign w_rise   = !i_error[W+3] && (i_error != '0);
    assign o_walk_x = i_walk_x + {{W{1'b0}}, 1'b1};
    assign o_walk_y = w_rise ? i_walk_y + {{W{1'b0}}, 1'b1} : i_walk_y;
    assign o_error  = w_rise ? i_error + {i_step_with_rise[W+2], i_step_with_rise}
                             : i_error + {1'b0, i_step_no_rise};
    assign o_last   = (o_walk_x >= i_final_x);

endmodule

[hw/rtl/lpw_octant_unfold.sv]
// ----------------------------------------------------------------------------
// lpw_octant_unfold
// maps an octant-zero pixel back to true coordinates
// ----------------------------------------------------------------------------
module lpw_octant_unfold #(
    parameter int COORD_BITS = 16
) (
    input  lpw_pkg::t_octant             i_octant,
    input  logic signed [COORD_BITS:0]   i_walk_x,
    input  logic signed [COORD_BITS:0]   i_walk_y,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y
);
    import lpw_pkg::*;

    localparam int W = COORD_BITS;

    logic signed [W-1:0] w_x, w_y, w_nx, w_ny;

    // wraparound to the output width commutes with negation
    assign w_x  = i_walk_x[W-1:0];
    assign w_y  = i_walk_y[W-1:0];
    assign w_nx = -w_x;
    assign w_ny = -w_y;

    always_comb begin
        case (i_octant)
            OCT_0:   begin o_pixel_x = w_x;  o_pixel_y = w_y;  end
            OCT_1:   begin o_pixel_x = w_y;  o_pixel_y = w_x;  end
            OCT_2:   begin o_pixel_x = w_ny; o_pixel_y = w_x;  end
            OCT_3:   begin o_pixel_x = w_nx; o_pixel_y = w_y;  end
            OCT_4:   begin o_pixel_x = w_nx; o_pixel_y = w_ny; end
            OCT_5:   begin o_pixel_x = w_ny; o_pixel_y = w_nx; end
            OCT_6:   begin o_pixel_x = w_y;  o_pixel_y = w_nx; end
            OCT_7:   begin o_pixel_x = w_x;  o_pixel_y = w_ny; end
            default: begin o_pixel_x = w_x;  o_pixel_y = w_y;  end
        endcase
    end

endmodule
